/* sv/spg_pkg.sv */
package spg_pkg;

	// input item function codes
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_SERVO = 2'd1,
		FUNC_ESC   = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// configuration register indexes
	localparam logic REG_PERIOD      = 1'b0;
	localparam logic REG_US_PER_TICK = 1'b1;

	localparam int CFG_W      = 16;
	localparam int PIN_OUT_W  = 4;
	localparam int US_W       = 12;
	localparam int DVD_W      = 25;
	localparam int DIV_STEPS  = DVD_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [CFG_W-1:0] PERIOD_RST    = 16'd63396;
	localparam logic [CFG_W-1:0] US_PER_TICK_RST = 16'd3155;
	localparam logic [CFG_W-1:0] WIDTH_RST     = 16'd12000;
	localparam logic [13:0]      US_SCALE      = 14'd10000;

	localparam logic signed [16:0] SERVO_MIN   = -17'sd150;
	localparam logic signed [16:0] SERVO_MAX   = 17'sd150;
	localparam logic signed [16:0] ESC_MAX     = 17'sd100;
	localparam logic [US_W-1:0]    SERVO_MID   = 12'd1500;
	localparam logic [US_W-1:0]    ESC_BASE    = 12'd1000;

	typedef struct packed {
		logic tick;      // advance the frame counter
		logic load;      // convert value and start a divide
		logic step;      // one divide iteration
		logic store_wr;  // write the quotient into the width store
		logic push;      // push a result item
	} spg_cmd_t;

	typedef struct packed {
		logic div_last;
	} spg_sts_t;

	typedef struct packed {
		logic [PIN_OUT_W-1:0] pins;
		logic                 start;
	} spg_res_t;

endpackage

/* sv/spg_ctrl.sv */
module spg_ctrl
	import spg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  func_t    func,
	input  logic     q_full,
	input  spg_sts_t sts,
	output logic     in_stall,
	output spg_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WB
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE) | q_full;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func) inside
						FUNC_TICK: begin
							cmd.tick = 1'b1;
							cmd.push = 1'b1;
						end
						FUNC_SERVO, FUNC_ESC: cmd.load = 1'b1;
						default: cmd.push = 1'b1;
					endcase
				end
			end
			ST_DIV: cmd.step = 1'b1;
			ST_WB: begin
				cmd.store_wr = 1'b1;
				cmd.push     = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_DIV;
				ST_DIV:  if (sts.div_last) state_q <= ST_WB;
				ST_WB:   state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/spg_dp.sv */
module spg_dp
	import spg_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  func_t                   func,
	input  logic [1:0]              channel,
	input  logic signed [16:0]      value,
	input  spg_cmd_t                cmd,
	output spg_sts_t                sts,
	output spg_res_t                res
);

	logic [CFG_W-1:0]        period_q;
	logic [CFG_W-1:0]        upt_q;
	logic [CFG_W-1:0]        cnt_q;
	logic [CFG_W-1:0]        width_q [NUM_CHANNELS];
	logic [CFG_W-1:0]        cmp_q   [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] pins_q;
	logic [1:0]              chan_q;
	logic                    chan_ok_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [CFG_W:0]          rem_q;
	logic [STEP_W-1:0]       step_q;

	logic                    wrap;
	logic [CFG_W-1:0]        cnt_inc;
	logic [CFG_W-1:0]        cnt_next;
	logic [NUM_CHANNELS-1:0] pins_next;
	logic signed [16:0]      v_servo;
	logic signed [16:0]      v_esc;
	logic [US_W-1:0]         us;
	logic [DVD_W-1:0]        dividend;
	logic [CFG_W:0]          rem_sh;
	logic                    q_bit;
	logic [CFG_W-1:0]        quot_sat;

	// frame counter step
	assign wrap     = cnt_q >= period_q;
	assign cnt_inc  = cnt_q + 16'd1;
	assign cnt_next = wrap ? '0 : cnt_inc;

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (wrap) pins_next[i] = (width_q[i] != '0);
			else      pins_next[i] = pins_q[i] & (cmp_q[i] != cnt_inc);
		end
	end

	// result: pins after this item, low lanes only
	always_comb begin
		res.start = cmd.tick & wrap;
		for (int i = 0; i < PIN_OUT_W; i++) begin
			if (i < NUM_CHANNELS) begin
				res.pins[i] = cmd.tick ? pins_next[i % NUM_CHANNELS]
				                       : pins_q[i % NUM_CHANNELS];
			end else begin
				res.pins[i] = 1'b0;
			end
		end
	end

	// value to microseconds, shift-add only
	always_comb begin
		v_servo = value;
		if (value < SERVO_MIN) v_servo = SERVO_MIN;
		if (value > SERVO_MAX) v_servo = SERVO_MAX;
		v_esc = value;
		if (value < 17'sd0)   v_esc = '0;
		if (value > ESC_MAX)  v_esc = ESC_MAX;
		if (func == FUNC_SERVO) begin
			us = SERVO_MID + US_W'(v_servo <<< 2) + US_W'(v_servo);
		end else begin
			us = ESC_BASE + US_W'(v_esc <<< 3) + US_W'(v_esc <<< 1);
		end
	end

	assign dividend = DVD_W'({13'd0, us} * {11'd0, US_SCALE});

	// restoring divide, one quotient bit per cycle; dvd_q collects the quotient
	assign rem_sh   = {rem_q[CFG_W-1:0], dvd_q[DVD_W-1]};
	assign q_bit    = rem_sh >= {1'b0, upt_q};
	assign quot_sat = (|dvd_q[DVD_W-1:CFG_W]) ? '1 : dvd_q[CFG_W-1:0];
	assign sts.div_last = step_q == STEP_W'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			upt_q    <= US_PER_TICK_RST;
			cnt_q    <= '0;
			pins_q   <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				width_q[i] <= WIDTH_RST;
				cmp_q[i]   <= '0;
			end
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					REG_PERIOD:      period_q <= cfg_data;
					REG_US_PER_TICK: upt_q    <= cfg_data;
					default:         ;
				endcase
			end
			if (cmd.tick) begin
				cnt_q  <= cnt_next;
				pins_q <= pins_next;
				if (wrap) begin
					for (int i = 0; i < NUM_CHANNELS; i++) cmp_q[i] <= width_q[i];
				end
			end
			if (cmd.store_wr && chan_ok_q) begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (32'(chan_q) == i) width_q[i] <= quot_sat;
				end
			end
		end
	end

	// divider payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q     <= dividend;
			rem_q     <= '0;
			step_q    <= '0;
			chan_q    <= channel;
			chan_ok_q <= 32'(channel) < NUM_CHANNELS;
		end else if (cmd.step) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], q_bit};
			rem_q  <= q_bit ? rem_sh - {1'b0, upt_q} : rem_sh;
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

/* sv/spg_outq.sv */
module spg_outq
	import spg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  spg_res_t push_data,
	input  logic     out_stall,
	output logic     out_valid,
	output spg_res_t head,
	output logic     full
);

	// two-entry result queue: head register plus skid entry
	logic [1:0] count_q;
	spg_res_t   head_q;
	spg_res_t   tail_q;
	logic       pop;

	assign out_valid = count_q != 2'd0;
	assign full      = count_q == 2'd2;
	assign pop       = out_valid & ~out_stall;
	assign head      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) head_q <= push_data;
				else                 tail_q <= push_data;
			end
			2'b01: head_q <= tail_q;
			2'b11: begin
				if (count_q == 2'd1) begin
					head_q <= push_data;
				end else begin
					head_q <= tail_q;
					tail_q <= push_data;
				end
			end
			default: ;
		endcase
	end

endmodule

/* sv/servo_pwm_generator_4ch_unit.sv */
// Four-channel RC servo / ESC pulse generator.
//
// Input channel (in_valid / in_stall): func, channel, value. A tick item
// advances the frame counter; at wrap the stored pulse widths become the
// compare values and pins with a nonzero width go high, and each pin drops when the counter
// reaches its compare. Set items convert a clamped deflection into ticks and
// store it for the channel, taking effect at the next frame start.
// Output channel (out_valid / out_stall): one item per input item with the
// pin levels after that item and frame_start.
// Config port (cfg_valid / cfg_ready, always ready): index 0 period_ticks,
// index 1 us_per_tick_scaled. Write only while the block is idle.
// Timing: tick and unused codes finish on accept, result valid the cycle after
// accept. A set item runs load, 25 restoring divide iterations of the shared
// divider, then write-back; the next item is accepted after that.
// A two-entry output queue lets inputs keep flowing while one result waits;
// with the queue full, in_stall is held high until the receiver takes one.
// Reset: counter and compares zero, pins low, widths 12000, config defaults.
module servo_pwm_generator_4ch_unit
	import spg_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [1:0]           channel,
	input  logic signed [16:0]   value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIN_OUT_W-1:0] pin_levels,
	output logic                 frame_start,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	spg_cmd_t cmd;
	spg_sts_t sts;
	spg_res_t res;
	spg_res_t head;
	logic     q_full;
	func_t    func_c;

	assign cfg_ready = 1'b1;
	assign func_c    = func_t'(func);

	spg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func_c),
		.q_full   (q_full),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	spg_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.func      (func_c),
		.channel   (channel),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

	spg_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.push),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.full      (q_full)
	);

	assign pin_levels  = head.pins;
	assign frame_start = head.start;

	// a set item blocks the input until its write-back
	a_set_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall)
		else $error("input not stalled during divide");

	// a tick result is presented on the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> out_valid)
		else $error("tick result missing");

	// never push into a full queue that is not draining
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && q_full && out_stall))
		else $error("result queue overflow");

	// only one command source per cycle: tick and divide never overlap
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.tick, cmd.load, cmd.step, cmd.store_wr}))
		else $error("conflicting datapath commands");

endmodule
